### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the encoder back end (fenc_back).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a named clock and reset.
`define FENC_ASSERT_ON(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Concurrent assertion on the module's clk and rst.
`define FENC_ASSERT(lbl, prop, msg) `FENC_ASSERT_ON(lbl, clk, rst, prop, msg)

`endif

### design/fenc_pkg.sv
// ----------------------------------------------------------------------------
// fenc_pkg
// Shared constants, command types and helpers of the forest encoder.
// ----------------------------------------------------------------------------
package fenc_pkg;

  localparam int NODE_COUNT     = 1024;
  localparam int SYMBOL_COUNT   = 256;
  localparam int MAX_WORD_BYTES = 4;
  localparam int ROOT_SLOTS     = 256;
  localparam int NODE_W         = $clog2(NODE_COUNT);
  localparam int SYM_W          = $clog2(SYMBOL_COUNT);
  localparam int LINK_W         = NODE_W + SYM_W;
  localparam int STEPS_W        = $clog2(NODE_COUNT + 1);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // Input operation codes.
  localparam logic [2:0] OP_LOAD_NODE = 3'd0;
  localparam logic [2:0] OP_LOAD_LINK = 3'd1;
  localparam logic [2:0] OP_LOAD_ROOT = 3'd2;
  localparam logic [2:0] OP_SAMPLE    = 3'd3;
  localparam logic [2:0] OP_END_BLOCK = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_MAX_EXPECTED = 1'b0;
  localparam logic CFG_CODE_BYTES   = 1'b1;

  typedef enum logic [2:0] {
    CMD_LOAD_NODE,
    CMD_LOAD_LINK,
    CMD_LOAD_ROOT,
    CMD_SAMPLE,
    CMD_END,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [9:0]  node;
    logic [7:0]  sym;
    logic [8:0]  total;
    logic [31:0] word;
    logic [9:0]  target;
    logic [7:0]  slot;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT0,
    S_NODE,
    S_ROOT,
    S_LINK
  } back_state_t;

  // Mask that keeps the low bytes of a codeword, with the byte count clamped.
  function automatic logic [31:0] word_mask(input logic [2:0] bpw);
    logic [2:0] n;
    n = bpw;
    if (n == 3'd0) n = 3'd1;
    if (int'(n) > MAX_WORD_BYTES) n = 3'(MAX_WORD_BYTES);
    return 32'hFFFF_FFFF >> (6'd32 - {n, 3'b000});
  endfunction

endpackage

### design/fenc_in_if.sv
// ----------------------------------------------------------------------------
// fenc_in_if
// Input channel: one load, sample or end-of-block word per handshake.
// ----------------------------------------------------------------------------
interface fenc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [9:0]  node_index;
  logic [7:0]  symbol;
  logic [8:0]  child_total;
  logic [31:0] node_code;
  logic [9:0]  target_node;
  logic [7:0]  root_slot;

  modport source (output valid, op, node_index, symbol, child_total, node_code,
                  target_node, root_slot, input ready);
  modport sink (input valid, op, node_index, symbol, child_total, node_code,
                target_node, root_slot, output ready);
endinterface

### design/fenc_out_if.sv
// ----------------------------------------------------------------------------
// fenc_out_if
// Result channel: one codeword or error word per handshake.
// ----------------------------------------------------------------------------
interface fenc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] codeword;
  logic        block_last;
  logic        sample_error;

  modport source (output valid, codeword, block_last, sample_error, input ready);
  modport sink (input valid, codeword, block_last, sample_error, output ready);
endinterface

### design/fenc_front.sv
// ----------------------------------------------------------------------------
// fenc_front
// Accepts input words, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module fenc_front (
  input  logic             clk,
  input  logic             rst,
  fenc_in_if.sink          in_ch,
  input  logic [7:0]       max_expected,
  output fenc_pkg::cmd_t   cmd,
  output logic             cmd_valid,
  input  logic             cmd_pop
);

  fenc_pkg::cmd_t                   entries [fenc_pkg::QUEUE_DEPTH];
  logic [fenc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [fenc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [fenc_pkg::QCNT_W-1:0]      count;
  fenc_pkg::cmd_t                   classified;
  logic                             keep;
  logic                             push;
  logic                             pop;

  // Classify the incoming word; out-of-range loads and unknown ops are dropped.
  always_comb begin
    classified.node   = in_ch.node_index;
    classified.sym    = in_ch.symbol;
    classified.total  = in_ch.child_total;
    classified.word   = in_ch.node_code;
    classified.target = in_ch.target_node;
    classified.slot   = in_ch.root_slot;
    classified.kind   = fenc_pkg::CMD_SAMPLE;
    keep              = 1'b0;
    unique case (in_ch.op)
      fenc_pkg::OP_LOAD_NODE: begin
        classified.kind = fenc_pkg::CMD_LOAD_NODE;
        keep = int'(in_ch.node_index) < fenc_pkg::NODE_COUNT;
      end
      fenc_pkg::OP_LOAD_LINK: begin
        classified.kind = fenc_pkg::CMD_LOAD_LINK;
        keep = int'(in_ch.node_index) < fenc_pkg::NODE_COUNT &&
               int'(in_ch.symbol) < fenc_pkg::SYMBOL_COUNT &&
               int'(in_ch.target_node) < fenc_pkg::NODE_COUNT;
      end
      fenc_pkg::OP_LOAD_ROOT: begin
        classified.kind = fenc_pkg::CMD_LOAD_ROOT;
        keep = int'(in_ch.target_node) < fenc_pkg::NODE_COUNT;
      end
      fenc_pkg::OP_SAMPLE: begin
        keep = 1'b1;
        if (in_ch.symbol > max_expected ||
            int'(in_ch.symbol) >= fenc_pkg::SYMBOL_COUNT) begin
          classified.kind = fenc_pkg::CMD_ERROR;
        end
      end
      fenc_pkg::OP_END_BLOCK: begin
        classified.kind = fenc_pkg::CMD_END;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Handshake and queue bookkeeping.
  assign in_ch.ready = count != fenc_pkg::QCNT_W'(fenc_pkg::QUEUE_DEPTH);
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign cmd_valid   = count != '0;
  assign pop         = cmd_pop && cmd_valid;
  assign cmd         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= classified;
  end

endmodule

### design/fenc_back.sv
// ----------------------------------------------------------------------------
// fenc_back
// Holds the code tables and walks the trees, one table read per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fenc_back (
  input  logic             clk,
  input  logic             rst,
  input  fenc_pkg::cmd_t   cmd,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  logic [7:0]       max_expected,
  input  logic [2:0]       code_bytes,
  fenc_out_if.source       out_ch
);

  // Tables.
  logic [8:0]                  cnt_mem  [fenc_pkg::NODE_COUNT];
  logic [31:0]                 word_mem [fenc_pkg::NODE_COUNT];
  logic [fenc_pkg::NODE_W-1:0] link_mem [fenc_pkg::NODE_COUNT * fenc_pkg::SYMBOL_COUNT];
  logic [fenc_pkg::NODE_W-1:0] root_mem [fenc_pkg::ROOT_SLOTS];

  logic [8:0]                  cnt_q;
  logic [31:0]                 word_q;
  logic [fenc_pkg::NODE_W-1:0] link_q;
  logic [fenc_pkg::NODE_W-1:0] root_q;

  logic [fenc_pkg::NODE_W-1:0] node_rd_addr;
  logic [fenc_pkg::LINK_W-1:0] link_rd_addr;
  logic [7:0]                  root_rd_addr;

  fenc_pkg::back_state_t       state;
  fenc_pkg::back_state_t       state_next;
  fenc_pkg::cmd_t              cmd_q;
  logic [fenc_pkg::NODE_W-1:0] cur;
  logic                        at_start;
  logic [fenc_pkg::STEPS_W-1:0] steps;

  logic                        out_free;
  logic                        is_load;
  logic                        is_walk;
  logic                        hit;
  logic                        follow;
  logic                        emit;
  logic [31:0]                 emit_word;
  logic                        emit_last;
  logic                        emit_err;
  logic                        cur_load;
  logic [fenc_pkg::NODE_W-1:0] cur_value;
  logic                        start_set;
  logic                        start_clr;
  logic                        steps_clr;
  logic                        steps_inc;

  assign out_free = !out_ch.valid || out_ch.ready;
  assign is_load  = cmd.kind == fenc_pkg::CMD_LOAD_NODE ||
                    cmd.kind == fenc_pkg::CMD_LOAD_LINK ||
                    cmd.kind == fenc_pkg::CMD_LOAD_ROOT;
  assign is_walk  = cmd.kind == fenc_pkg::CMD_SAMPLE || cmd.kind == fenc_pkg::CMD_END;
  assign cmd_pop  = state == fenc_pkg::S_IDLE && cmd_valid && (is_load || out_free);

  // Node decisions on the registered node read.
  assign hit    = {1'b0, cmd_q.sym} >= cnt_q;
  assign follow = int'(steps) < fenc_pkg::NODE_COUNT &&
                  cnt_q == ({1'b0, max_expected} + 9'd1);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fenc_pkg::S_IDLE: begin
        if (cmd_pop && is_walk) begin
          state_next = at_start ? fenc_pkg::S_ROOT0 : fenc_pkg::S_NODE;
        end
      end
      fenc_pkg::S_ROOT0: state_next = fenc_pkg::S_NODE;
      fenc_pkg::S_NODE: begin
        if (cmd_q.kind == fenc_pkg::CMD_SAMPLE) begin
          state_next = hit ? fenc_pkg::S_ROOT : fenc_pkg::S_LINK;
        end else begin
          state_next = follow ? fenc_pkg::S_LINK : fenc_pkg::S_IDLE;
        end
      end
      fenc_pkg::S_ROOT: state_next = fenc_pkg::S_LINK;
      fenc_pkg::S_LINK: begin
        state_next = (cmd_q.kind == fenc_pkg::CMD_SAMPLE) ? fenc_pkg::S_IDLE
                                                          : fenc_pkg::S_NODE;
      end
      default: state_next = fenc_pkg::S_IDLE;
    endcase
  end

  // Read addresses, result and walk updates for each state.
  always_comb begin
    node_rd_addr = cur;
    link_rd_addr = {cur, cmd_q.sym[fenc_pkg::SYM_W-1:0]};
    root_rd_addr = 8'd0;
    emit         = 1'b0;
    emit_word    = word_q & fenc_pkg::word_mask(code_bytes);
    emit_last    = 1'b0;
    emit_err     = 1'b0;
    cur_load     = 1'b0;
    cur_value    = link_q;
    start_set    = 1'b0;
    start_clr    = 1'b0;
    steps_clr    = 1'b0;
    steps_inc    = 1'b0;
    unique case (state)
      fenc_pkg::S_IDLE: begin
        steps_clr = 1'b1;
        if (cmd_pop && cmd.kind == fenc_pkg::CMD_ERROR) begin
          emit      = 1'b1;
          emit_err  = 1'b1;
          emit_word = 32'd0;
        end
      end
      fenc_pkg::S_ROOT0: begin
        cur_load     = 1'b1;
        cur_value    = root_q;
        start_clr    = 1'b1;
        node_rd_addr = root_q;
      end
      fenc_pkg::S_NODE: begin
        if (cmd_q.kind == fenc_pkg::CMD_SAMPLE) begin
          emit         = hit;
          root_rd_addr = cnt_q[7:0];
        end else if (follow) begin
          link_rd_addr = {cur, fenc_pkg::SYM_W'(0)};
          steps_inc    = 1'b1;
        end else begin
          emit      = 1'b1;
          emit_last = 1'b1;
          cur_load  = 1'b1;
          cur_value = '0;
          start_set = 1'b1;
        end
      end
      fenc_pkg::S_ROOT: begin
        link_rd_addr = {root_q, cmd_q.sym[fenc_pkg::SYM_W-1:0]};
      end
      fenc_pkg::S_LINK: begin
        cur_load     = 1'b1;
        node_rd_addr = link_q;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Table writes from loads and registered table reads.
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == fenc_pkg::CMD_LOAD_NODE) begin
      cnt_mem[cmd.node[fenc_pkg::NODE_W-1:0]]  <= cmd.total;
      word_mem[cmd.node[fenc_pkg::NODE_W-1:0]] <= cmd.word;
    end
    cnt_q  <= cnt_mem[node_rd_addr];
    word_q <= word_mem[node_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == fenc_pkg::CMD_LOAD_LINK) begin
      link_mem[{cmd.node[fenc_pkg::NODE_W-1:0], cmd.sym[fenc_pkg::SYM_W-1:0]}] <=
        cmd.target[fenc_pkg::NODE_W-1:0];
    end
    link_q <= link_mem[link_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == fenc_pkg::CMD_LOAD_ROOT) begin
      root_mem[cmd.slot] <= cmd.target[fenc_pkg::NODE_W-1:0];
    end
    root_q <= root_mem[root_rd_addr];
  end

  // Sequencer and walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fenc_pkg::S_IDLE;
      cur      <= '0;
      at_start <= 1'b1;
      steps    <= '0;
    end else begin
      state <= state_next;
      if (cur_load) cur <= cur_value;
      if (start_set) at_start <= 1'b1;
      else if (start_clr) at_start <= 1'b0;
      if (steps_clr) steps <= '0;
      else if (steps_inc) steps <= steps + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_q <= cmd;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (emit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.codeword     <= emit_word;
      out_ch.block_last   <= emit_last;
      out_ch.sample_error <= emit_err;
    end
  end

  `FENC_ASSERT(a_emit_slot_free, emit |-> out_free, "result overwrites a pending word")
  `FENC_ASSERT(a_steps_bound, int'(steps) <= fenc_pkg::NODE_COUNT, "walk ran past its bound")
  `FENC_ASSERT(a_end_restarts, (state == fenc_pkg::S_NODE && emit_last) |=> at_start, "no restart")

endmodule

### design/v2f_forest_encoder_unit.sv
// From dequeue, a load or rejected sample is handled in the idle state; a sample walks a
// node read and a link read, or node, root and link reads when it emits; an end-of-block
// word walks a node read plus a link and node read per followed child-0 link; and the first
// walk of a block starts with a root-0 read. One item is walked at a time on single-port
// tables, so a new item is taken only once the last is through; a 2-entry queue decouples input.
// Reset (rst, synchronous) clears control and sets the registers; tables are not cleared.
// ----------------------------------------------------------------------------
// v2f_forest_encoder_unit
// Variable-to-fixed forest encoder: input queue front end and table-walking back end.
// ----------------------------------------------------------------------------
module v2f_forest_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  fenc_in_if.sink     in_ch,
  fenc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0]     max_expected;
  logic [2:0]     code_bytes;
  fenc_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_expected <= 8'd255;
      code_bytes   <= 3'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fenc_pkg::CFG_MAX_EXPECTED: max_expected <= cfg_data;
        fenc_pkg::CFG_CODE_BYTES:   code_bytes   <= cfg_data[2:0];
        default:                    max_expected <= max_expected;
      endcase
    end
  end

  fenc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .max_expected (max_expected),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop)
  );

  fenc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .max_expected (max_expected),
    .code_bytes   (code_bytes),
    .out_ch       (out_ch)
  );

endmodule
